/* sv/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg: shared definitions of the serial frame receiver
// Register indexes, result status codes, reset values and the structs that
// travel between the parser, the job queue and the result generator.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN  = 2'd2;

    localparam logic [7:0]  HEADER_RST  = 8'd170;
    localparam logic [15:0] TIMEOUT_RST = 16'd50;
    localparam logic [5:0]  MAXLEN_RST  = 6'd32;

    localparam logic [2:0] ST_GOOD    = 3'd0;
    localparam logic [2:0] ST_BADSUM  = 3'd1;
    localparam logic [2:0] ST_TOOLONG = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_BADHDR  = 3'd4;

    // One finished frame outcome, handed from the parser to the result side.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] cmd;
        logic [7:0] len;
        logic       has_data;
    } job_t;

    // Status reported by the result side back to the parser.
    typedef struct packed {
        logic run_done;
    } back_stat_t;

endpackage

/* sv/sfr_ifs.sv */
// ----------------------------------------------------------------------------
// sfr_ifs: request channels of the serial frame receiver
// Valid/ready channels for received items and for produced results.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface sfr_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] msg_command;
    logic [7:0] msg_length;
    logic       has_data;
    logic [4:0] byte_index;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output status, output msg_command, output msg_length,
                    output has_data, output byte_index, output data_byte, output last,
                    input ready);
    modport sink (input valid, input status, input msg_command, input msg_length,
                  input has_data, input byte_index, input data_byte, input last,
                  output ready);
endinterface

/* sv/serial_frame_receiver.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver: header / command / length / payload / checksum parser
// Parses framed serial input, checks length, timeout and checksum, and
// returns either a status result or the payload of a good frame.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake             Payload
//  rx_ch    in   valid / ready         command (0 byte, 1 tick), rx_byte
//  res_ch   out  valid / ready         status, msg_command, msg_length,
//                                      has_data, byte_index, data_byte, last
//  cfg      in   cfg_we (no stall)     cfg_index, cfg_data
//
// Received bytes and ticks are taken at one request per cycle. A good frame
// with a payload of N bytes gives N results, one per cycle. The job passes
// through the queue first, so the first result is loaded into the output
// register from the queue entry that the checksum byte writes;
// the single read port of the payload memory sets the pace of the run.
// rx_ch stalls from the checksum byte of a good frame with a payload until
// the last payload result is loaded, and whenever the two-entry job queue is
// full. Back-pressure on res_ch holds the output register and, through the
// queue, eventually stalls rx_ch. Reset is asynchronous and needs no clearing
// pass; configuration returns to 170 / 50 / 32.
//
module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sfr_rx_if.sink                rx_ch,
    sfr_res_if.source             res_ch
);

    // Address width of the payload memory and width of a count up to its depth.
    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

    logic [7:0]  header_reg;
    logic [15:0] timeout_reg;
    logic [5:0]  maxlen_reg;

    logic          push_valid;
    job_t          push_job;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    job_t          q_job;
    back_stat_t    bstat;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // Configuration registers. Writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RST;
            timeout_reg <= TIMEOUT_RST;
            maxlen_reg  <= MAXLEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER:  header_reg  <= cfg_data[7:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data[15:0];
                CFG_MAXLEN:  maxlen_reg  <= cfg_data[5:0];
                default:     ;
            endcase
        end
    end

    // Front: phase tracking, checksum, timeout and payload capture.
    sfr_front #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
        .AW(AW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .header_value(header_reg),
        .timeout_ticks(timeout_reg),
        .max_length(maxlen_reg),
        .rx(rx_ch),
        .push_valid(push_valid),
        .push_job(push_job),
        .q_full(q_full),
        .bstat(bstat),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    // Finished frame outcomes wait here until the result side is free.
    sfr_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_job(push_job),
        .full(q_full),
        .pop(q_pop),
        .pop_job(q_job),
        .not_empty(q_not_empty)
    );

    // Back: payload memory and result register.
    sfr_back #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
        .AW(AW),
        .CW(CW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .q_valid(q_not_empty),
        .q_job(q_job),
        .pop(q_pop),
        .bstat(bstat),
        .res(res_ch)
    );

endmodule

/* sv/sfr_front.sv */
// ----------------------------------------------------------------------------
// sfr_front: frame parser
// Accepts bytes and ticks, tracks the frame phase, stores payload bytes and
// pushes an outcome per finished frame or bad header byte into the job queue.
// ----------------------------------------------------------------------------
module sfr_front
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    parameter int AW            = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    header_value,
    input  logic [15:0]   timeout_ticks,
    input  logic [5:0]    max_length,
    sfr_rx_if.sink        rx,
    output logic          push_valid,
    output job_t          push_job,
    input  logic          q_full,
    input  back_stat_t    bstat,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CMD   = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_SUM   = 3'd4;
    localparam logic [2:0] PH_FLUSH = 3'd5;

    localparam logic [6:0] DEPTH_V = 7'(PAYLOAD_DEPTH);

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  len_reg, len_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] idle_reg, idle_next;
    logic        pend_reg, pend_next;

    logic        accept;
    logic [6:0]  limit;
    logic [15:0] tick_inc;
    logic [8:0]  cnt_inc;

    assign rx.ready = !q_full && !pend_reg;
    assign accept   = rx.valid && rx.ready;
    assign limit    = ({1'b0, max_length} < DEPTH_V) ? {1'b0, max_length} : DEPTH_V;
    assign tick_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign cnt_inc  = cnt_reg + 9'd1;
    assign wr_addr  = cnt_reg[AW-1:0];
    assign wr_data  = rx.rx_byte;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        idle_next  = idle_reg;
        pend_next  = bstat.run_done ? 1'b0 : pend_reg;
        push_valid = 1'b0;
        push_job   = '0;
        wr_en      = 1'b0;

        if (accept)
        begin
            if (rx.command)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    idle_next = tick_inc;
                    if (tick_inc >= timeout_ticks)
                    begin
                        push_valid = 1'b1;
                        push_job   = '{status: ST_TIMEOUT, cmd: cmd_reg, len: len_reg,
                                       has_data: 1'b0};
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                        sum_next   = '0;
                        idle_next  = '0;
                    end
                end
            end
            else
            begin
                idle_next = '0;
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (rx.rx_byte != header_value)
                        begin
                            push_valid = 1'b1;
                            push_job   = '{status: ST_BADHDR, cmd: 8'd0, len: 8'd0,
                                           has_data: 1'b0};
                        end
                        else
                        begin
                            cmd_next   = '0;
                            len_next   = '0;
                            sum_next   = '0;
                            cnt_next   = '0;
                            phase_next = PH_CMD;
                        end
                    end
                    PH_CMD:
                    begin
                        cmd_next   = rx.rx_byte;
                        sum_next   = rx.rx_byte;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        len_next = rx.rx_byte;
                        sum_next = sum_reg + rx.rx_byte;
                        cnt_next = '0;
                        if (rx.rx_byte > {1'b0, limit})
                            phase_next = PH_FLUSH;
                        else if (rx.rx_byte == 8'd0)
                            phase_next = PH_SUM;
                        else
                            phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        wr_en    = 1'b1;
                        sum_next = sum_reg + rx.rx_byte;
                        cnt_next = cnt_inc;
                        if (cnt_inc >= {1'b0, len_reg})
                            phase_next = PH_SUM;
                    end
                    PH_SUM:
                    begin
                        push_valid = 1'b1;
                        if (rx.rx_byte != sum_reg)
                        begin
                            push_job = '{status: ST_BADSUM, cmd: cmd_reg, len: len_reg,
                                         has_data: 1'b0};
                        end
                        else
                        begin
                            push_job = '{status: ST_GOOD, cmd: cmd_reg, len: len_reg,
                                         has_data: (len_reg != 8'd0)};
                            // Hold off new items until the payload has been read out.
                            if (len_reg != 8'd0)
                                pend_next = 1'b1;
                        end
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                        sum_next   = '0;
                    end
                    PH_FLUSH:
                    begin
                        cnt_next = cnt_inc;
                        if (cnt_inc >= {1'b0, len_reg} + 9'd1)
                        begin
                            push_valid = 1'b1;
                            push_job   = '{status: ST_TOOLONG, cmd: cmd_reg, len: len_reg,
                                           has_data: 1'b0};
                            phase_next = PH_IDLE;
                            cnt_next   = '0;
                            sum_next   = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                        sum_next   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            idle_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            idle_reg  <= idle_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

/* sv/sfr_queue.sv */
// ----------------------------------------------------------------------------
// sfr_queue: two-entry job queue
// Decouples the parser from the result generator.
// ----------------------------------------------------------------------------
module sfr_queue
    import sfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic not_empty
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/sfr_back.sv */
// ----------------------------------------------------------------------------
// sfr_back: result generator
// Holds the payload memory, takes jobs from the queue and drives the result
// channel, one result per cycle during a payload run unless res stalls.
// ----------------------------------------------------------------------------
module sfr_back
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    parameter int AW            = 5,
    parameter int CW            = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          q_valid,
    input  job_t          q_job,
    output logic          pop,
    output back_stat_t    bstat,
    sfr_res_if.source     res
);

    logic [7:0]    mem [PAYLOAD_DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] rd_addr;

    logic          run_reg, run_next;
    logic [CW-1:0] idx_reg, idx_next;
    job_t          job_reg, job_next;

    logic          valid_reg, valid_next;
    logic [2:0]    status_reg, status_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [7:0]    len_reg, len_next;
    logic          hd_reg, hd_next;
    logic [4:0]    bidx_reg, bidx_next;
    logic [7:0]    data_reg, data_next;
    logic          last_reg, last_next;

    logic          out_free;
    logic          run_last;

    assign out_free = !valid_reg || res.ready;
    assign run_last = (8'(idx_reg) + 8'd1) == job_reg.len;
    // The read address follows the next index, so the data is ready when needed.
    assign rd_addr  = idx_next[AW-1:0];

    always_comb
    begin
        run_next       = run_reg;
        idx_next       = idx_reg;
        job_next       = job_reg;
        valid_next     = valid_reg;
        status_next    = status_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        hd_next        = hd_reg;
        bidx_next      = bidx_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        bstat.run_done = 1'b0;

        if (out_free)
        begin
            if (run_reg)
            begin
                valid_next  = 1'b1;
                status_next = job_reg.status;
                cmd_next    = job_reg.cmd;
                len_next    = job_reg.len;
                hd_next     = 1'b1;
                bidx_next   = 5'(idx_reg);
                data_next   = rdata_reg;
                last_next   = run_last;
                if (run_last)
                begin
                    run_next       = 1'b0;
                    idx_next       = '0;
                    bstat.run_done = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            else if (q_valid)
            begin
                pop         = 1'b1;
                job_next    = q_job;
                valid_next  = 1'b1;
                status_next = q_job.status;
                cmd_next    = q_job.cmd;
                len_next    = q_job.len;
                hd_next     = q_job.has_data;
                bidx_next   = '0;
                if (q_job.has_data)
                begin
                    data_next = rdata_reg;
                    last_next = (q_job.len == 8'd1);
                    if (q_job.len == 8'd1)
                    begin
                        bstat.run_done = 1'b1;
                    end
                    else
                    begin
                        run_next = 1'b1;
                        idx_next = CW'(1);
                    end
                end
                else
                begin
                    data_next = '0;
                    last_next = 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        status_reg <= status_next;
        cmd_reg    <= cmd_next;
        len_reg    <= len_next;
        hd_reg     <= hd_next;
        bidx_reg   <= bidx_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign res.valid       = valid_reg;
    assign res.status      = status_reg;
    assign res.msg_command = cmd_reg;
    assign res.msg_length  = len_reg;
    assign res.has_data    = hd_reg;
    assign res.byte_index  = bidx_reg;
    assign res.data_byte   = data_reg;
    assign res.last        = last_reg;

endmodule

/* sv/sfr_checker.sv */
// ----------------------------------------------------------------------------
// sfr_checker: port-level checks of the serial frame receiver
// Watches the result channel and flags illegal or inconsistent results.
// ----------------------------------------------------------------------------
module sfr_checker
    import sfr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] status,
    input logic       has_data,
    input logic [4:0] byte_index,
    input logic [7:0] data_byte,
    input logic       last
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(has_data)
            && $stable(byte_index) && $stable(data_byte) && $stable(last))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status <= ST_BADHDR)
        else $error("undefined status code");

    // Payload bytes only come with a good frame.
    a_data_good: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && has_data |-> status == ST_GOOD)
        else $error("payload byte on a failed frame");

    // A result without data is alone and fully zeroed.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !has_data |-> last && byte_index == 5'd0 && data_byte == 8'd0)
        else $error("malformed result without data");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(res_ch.valid),
    .res_ready(res_ch.ready),
    .status(res_ch.status),
    .has_data(res_ch.has_data),
    .byte_index(res_ch.byte_index),
    .data_byte(res_ch.data_byte),
    .last(res_ch.last)
);
